### sv/skf_pkg.sv
// Shared types, constants and reset-value functions of the scalar Kalman filter.
package skf_pkg;

    // Default fixed-point formats
    localparam int COV_FRAC_BITS_DEF = 24;
    localparam int EST_FRAC_BITS_DEF = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_PROCESS_NOISE      = 2'd0;
    localparam logic [1:0] REG_MEASUREMENT_NOISE  = 2'd1;
    localparam logic [1:0] REG_INITIAL_COVARIANCE = 2'd2;

    // Request word handed to the gain divider
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [32:0] den;
    } div_req_t;

    // Reset of the process noise: round(0.003 * 2^frac)
    function automatic logic [31:0] q_reset(input int frac);
        logic [63:0] v;
        v = ((64'd3 << frac) + 64'd500) / 64'd1000;
        return v[31:0];
    endfunction

    // Reset of the measurement noise: 0.5 * 2^frac
    function automatic logic [31:0] r_reset(input int frac);
        logic [63:0] v;
        v = 64'd1 << (frac - 1);
        return v[31:0];
    endfunction

    // Reset of the initial covariance: round(0.001 * 2^frac)
    function automatic logic [31:0] p0_reset(input int frac);
        logic [63:0] v;
        v = ((64'd1 << frac) + 64'd500) / 64'd1000;
        return v[31:0];
    endfunction

endpackage

### sv/skf_div.sv
// Restoring divider producing the gain, one quotient bit per cycle.
module skf_div
    import skf_pkg::*;
#(
    parameter int COV_FRAC_BITS = COV_FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  div_req_t                 req,
    output logic                     done,
    output logic [COV_FRAC_BITS:0]   quot
);

    localparam int CW = $clog2(COV_FRAC_BITS + 1);

    logic [32:0]            rem_reg, rem_next;
    logic [COV_FRAC_BITS:0] quot_reg, quot_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   lsb_reg, lsb_next;
    logic [32:0]            den_reg, den_next;
    logic [33:0]            shifted;
    logic                   ge;

    // Shift in the next dividend bit; only the first step carries one
    always_comb
    begin
        shifted = {rem_reg, (cnt_reg == CW'(COV_FRAC_BITS)) ? lsb_reg : 1'b0};
        ge      = (shifted >= {1'b0, den_reg});
    end

    // Sequence the iterations
    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        lsb_next  = lsb_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = {2'b00, req.num[31:1]};
            lsb_next  = req.num[0];
            den_next  = req.den;
            cnt_next  = CW'(COV_FRAC_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? 33'(shifted - {1'b0, den_reg}) : shifted[32:0];
            quot_next = {quot_reg[COV_FRAC_BITS-1:0], ge};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        lsb_reg  <= lsb_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### sv/scalar_kalman_filter.sv
// Top level of the scalar Kalman filter: sequencer, shared multiplier and state.
//
// One-dimensional Kalman filter on signed 16-bit samples. Each sample goes
// through the gain divider, which yields one quotient bit per cycle, then
// through the single shared multiplier twice before the word is offered on
// the output; the covariance is Q8.24 by default. s_tready is high only while
// the sequencer is idle; a finished word waits in the output register, so the
// next sample is taken while it is still pending. Register writes must be
// made while idle; writing initial_covariance reloads the covariance and
// clears the estimate.
module scalar_kalman_filter
    import skf_pkg::*;
#(
    parameter int COV_FRAC_BITS = COV_FRAC_BITS_DEF,
    parameter int EST_FRAC_BITS = EST_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] measurement
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] filtered
    // Configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int GW = COV_FRAC_BITS + 1;
    localparam int PW = 32 + GW;
    localparam logic [GW-1:0] GAIN_ONE = GW'(1) << COV_FRAC_BITS;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PRED = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_MULE = 6'b001000,
        ST_MULC = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic [31:0]     q_reg, r_reg;
    logic [31:0]     cov_reg, cov_next;
    logic [31:0]     est_reg, est_next;
    logic [15:0]     meas_reg;
    logic [31:0]     p_reg, p_next;
    logic            zero_reg, zero_next;
    logic [GW-1:0]   gain_reg, gain_next;
    logic            neg_reg, neg_next;
    logic [PW-1:0]   prod_reg;
    logic            out_valid_reg, out_valid_next;
    logic [15:0]     out_data_reg, out_data_next;

    logic [32:0]     p_sum, s_sum;
    div_req_t        div_req;
    logic            div_done;
    logic [GW-1:0]   div_quot;

    logic signed [47:0] m_wide;
    logic [31:0]     m_sat;
    logic [32:0]     diff;
    logic [31:0]     mag;
    logic [31:0]     mul_a;
    logic [GW-1:0]   mul_b;
    logic [31:0]     delta;
    logic            out_free;

    logic            est_neg;
    logic [32:0]     est_mag;
    logic [32:0]     est_int;
    logic [15:0]     filt;

    // Predict covariance with saturation, and form the gain denominator
    always_comb
    begin
        p_sum = {1'b0, cov_reg} + {1'b0, q_reg};
        p_next = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
        s_sum = {1'b0, p_next} + {1'b0, r_reg};
    end

    // Scaled measurement, saturated to the estimate range, and its distance
    always_comb
    begin
        m_wide = 48'(signed'(meas_reg)) <<< EST_FRAC_BITS;
        if (m_wide > 48'sd2147483647)
            m_sat = 32'h7FFF_FFFF;
        else if (m_wide < -48'sd2147483648)
            m_sat = 32'h8000_0000;
        else
            m_sat = m_wide[31:0];
        diff = {m_sat[31], m_sat} - {est_reg[31], est_reg};
        mag  = diff[32] ? 32'(-diff) : diff[31:0];
    end

    // Shared multiplier operands
    always_comb
    begin
        if (state_reg == ST_MULE)
        begin
            mul_a = mag;
            mul_b = gain_reg;
        end
        else
        begin
            mul_a = p_reg;
            mul_b = GAIN_ONE - gain_reg;
        end
        delta = prod_reg[COV_FRAC_BITS +: 32];
    end

    // Truncate the estimate toward zero and saturate to 16 bits
    always_comb
    begin
        est_neg = est_reg[31];
        est_mag = est_neg ? 33'(-{1'b1, est_reg}) : {1'b0, est_reg};
        est_int = est_mag >> EST_FRAC_BITS;
        if (!est_neg)
            filt = (est_int > 33'd32767) ? 16'h7FFF : est_int[15:0];
        else
            filt = (est_int > 33'd32768) ? 16'h8000 : 16'(-est_int[15:0]);
    end

    // Gain divider
    always_comb
    begin
        div_req.start = (state_reg == ST_PRED);
        div_req.num   = p_next;
        div_req.den   = s_sum;
    end

    skf_div #(
        .COV_FRAC_BITS(COV_FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_free = !out_valid_reg || m_tready;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        est_next       = est_reg;
        cov_next       = cov_reg;
        gain_next      = gain_reg;
        neg_next       = neg_reg;
        zero_next      = zero_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_PRED;
            end
            ST_PRED:
            begin
                zero_next  = (s_sum == '0);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    gain_next  = zero_reg ? '0 : div_quot;
                    state_next = ST_MULE;
                end
            end
            ST_MULE:
            begin
                neg_next   = diff[32];
                state_next = ST_MULC;
            end
            ST_MULC:
            begin
                est_next   = neg_reg ? est_reg - delta : est_reg + delta;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cov_next       = delta;
                    out_data_next  = filt;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // Reload the filter on a write of the initial covariance
        if (cfg_we && cfg_index == REG_INITIAL_COVARIANCE)
        begin
            cov_next = cfg_wdata;
            est_next = '0;
        end
    end

    // Control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            q_reg         <= q_reset(COV_FRAC_BITS);
            r_reg         <= r_reset(COV_FRAC_BITS);
            cov_reg       <= p0_reset(COV_FRAC_BITS);
            est_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cov_reg       <= cov_next;
            est_reg       <= est_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PROCESS_NOISE:      q_reg  <= cfg_wdata;
                    REG_MEASUREMENT_NOISE:  r_reg  <= cfg_wdata;
                    default:                ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
            meas_reg <= s_tdata;
        if (state_reg == ST_PRED)
            p_reg <= p_next;
        if (state_reg == ST_MULE || state_reg == ST_MULC)
            prod_reg <= PW'(mul_a) * PW'(mul_b);
        zero_reg     <= zero_next;
        gain_reg     <= gain_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### dv/skf_checker.sv
// Result checker of the scalar Kalman filter: tracks register writes, predicts each filtered word.
module skf_checker
    import skf_pkg::*;
#(
    parameter int COV_FRAC_BITS = COV_FRAC_BITS_DEF,
    parameter int EST_FRAC_BITS = EST_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] measurement
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // [15:0] filtered
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int unsigned n_errors,
    output int unsigned n_pending,
    output int unsigned n_checked
);

    localparam int MAX_PRINTED = 20;

    // Register values after reset, rounded to the covariance format
    localparam logic [63:0] Q_AT_RESET  = ((64'd3 << COV_FRAC_BITS) + 64'd500) / 64'd1000;
    localparam logic [63:0] R_AT_RESET  = 64'd1 << (COV_FRAC_BITS - 1);
    localparam logic [63:0] P0_AT_RESET = ((64'd1 << COV_FRAC_BITS) + 64'd500) / 64'd1000;

    localparam logic signed [63:0] EST_MAX = 64'sd2147483647;
    localparam logic signed [63:0] EST_MIN = -64'sd2147483648;

    logic [31:0]        q_noise;
    logic [31:0]        r_noise;
    logic [31:0]        cov_now;
    logic signed [31:0] est_now;

    logic [15:0] filtered_expected[$];
    logic [15:0] want_word;

    // Print one line per mismatch (up to a cap) and count it
    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_PRINTED)
            $display("MISMATCH @%0t: %s", $time, msg);
        n_errors++;
    endtask

    // Run one filter step on the tracked state and return the filtered word
    function automatic logic [15:0] advance_filter(input logic [15:0] sample);
        logic [63:0]        p;
        logic [63:0]        s;
        logic [63:0]        gain;
        logic [63:0]        mag;
        logic [63:0]        delta;
        logic [63:0]        prod;
        logic signed [63:0] meas;
        logic signed [63:0] m;
        logic signed [63:0] d;
        logic signed [63:0] base;
        logic signed [63:0] est;
        logic signed [63:0] whole;
        logic               neg;

        // predict covariance, clipped to 32 bits
        p = {32'd0, cov_now} + {32'd0, q_noise};
        if (p > 64'hFFFF_FFFF)
            p = 64'hFFFF_FFFF;

        // gain, forced to zero on an empty sum
        s = p + {32'd0, r_noise};
        gain = (s == 64'd0) ? 64'd0 : ((p << COV_FRAC_BITS) / s);

        // scale the sample into the estimate format
        meas = $signed(sample);
        m = meas <<< EST_FRAC_BITS;
        if (m > EST_MAX)
            m = EST_MAX;
        if (m < EST_MIN)
            m = EST_MIN;

        // move the estimate by the gain, truncating the step toward zero
        base = est_now;
        d = m - base;
        neg = (d < 0);
        mag = neg ? -d : d;
        delta = (mag * gain) >> COV_FRAC_BITS;
        est = neg ? (base - $signed(delta)) : (base + $signed(delta));
        est_now = est[31:0];

        // shrink the covariance by one minus the gain
        prod = p * ((64'd1 << COV_FRAC_BITS) - gain);
        prod = prod >> COV_FRAC_BITS;
        cov_now = prod[31:0];

        // integer part toward zero, clipped to 16 bits
        neg = (est < 0);
        mag = neg ? -est : est;
        mag = mag >> EST_FRAC_BITS;
        whole = neg ? -$signed(mag) : $signed(mag);
        if (whole > 64'sd32767)
            whole = 64'sd32767;
        if (whole < -64'sd32768)
            whole = -64'sd32768;
        return whole[15:0];
    endfunction

    // Follow writes, inputs and outputs at each clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_noise   = Q_AT_RESET[31:0];
            r_noise   = R_AT_RESET[31:0];
            cov_now   = P0_AT_RESET[31:0];
            est_now   = '0;
            filtered_expected.delete();
            n_errors  = 0;
            n_pending = 0;
            n_checked = 0;
        end
        else
        begin
            // register write; unmapped indexes are dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PROCESS_NOISE:      q_noise = cfg_wdata;
                    REG_MEASUREMENT_NOISE:  r_noise = cfg_wdata;
                    REG_INITIAL_COVARIANCE:
                    begin
                        cov_now = cfg_wdata;
                        est_now = '0;
                    end
                    default: ;
                endcase
            end

            // compare an outgoing word with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (filtered_expected.size() == 0)
                    report_mismatch($sformatf("unexpected filtered word %0d", $signed(m_tdata)));
                else
                begin
                    want_word = filtered_expected.pop_front();
                    n_checked++;
                    if (m_tdata !== want_word)
                        report_mismatch($sformatf("filtered: expected %0d, got %0d",
                                                  $signed(want_word), $signed(m_tdata)));
                end
            end

            // predict the word for an accepted sample
            if (s_tvalid && s_tready)
            begin
                want_word = advance_filter(s_tdata);
                filtered_expected.push_back(want_word);
            end

            n_pending = filtered_expected.size();
        end
    end

endmodule

### dv/tb.sv
// Testbench top of the scalar Kalman filter: clock, reset, sample and register stimulus, verdict.
module tb
    import skf_pkg::*;
();

    localparam int COV_BITS       = COV_FRAC_BITS_DEF;
    localparam int EST_BITS       = EST_FRAC_BITS_DEF;
    localparam int DRAIN_CYCLES   = COV_BITS + 12;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEMS_PER_SET  = 90;
    localparam int SETS_PER_MODE  = 5;

    // Index that maps to no register
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    int unsigned n_errors;
    int unsigned n_pending;
    int unsigned n_checked;

    int unsigned tx_idle_pct     = 0;
    int unsigned rx_idle_pct     = 0;
    int unsigned holds_requested = 0;
    int unsigned holds_done      = 0;
    int unsigned n_settings      = 0;
    int unsigned idle_cycles     = 0;
    int          level           = 0;

    scalar_kalman_filter #(
        .COV_FRAC_BITS (COV_BITS),
        .EST_FRAC_BITS (EST_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    skf_checker #(
        .COV_FRAC_BITS (COV_BITS),
        .EST_FRAC_BITS (EST_BITS)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .n_errors  (n_errors),
        .n_pending (n_pending),
        .n_checked (n_checked)
    );

    // Free-running clock, period 10
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side: random back-pressure, or a long hold when one is asked for
    initial
    begin
        forever
        begin
            if (holds_done != holds_requested)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
                @(posedge clk);
            end
        end
    end

    // Abort when nothing moves for too long
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Offer one sample word and hold it until it is taken
    task automatic send_sample(input logic [15:0] value);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
    endtask

    // Write one register, then wait with the write strobe low; caller makes sure the filter is idle
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering, wait for every predicted word, then let the pipeline settle
    task automatic drain_filter();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (n_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Load a full set of noise values and a starting covariance
    task automatic load_setting(input logic [31:0] q, input logic [31:0] r,
                                input logic [31:0] p0);
        write_reg(REG_PROCESS_NOISE, q);
        write_reg(REG_MEASUREMENT_NOISE, r);
        write_reg(REG_INITIAL_COVARIANCE, p0);
        n_settings++;
    endtask

    // Noise or covariance value: extremes, small, near one, or anything
    function automatic logic [31:0] pick_cov_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = 32'd0;
            1:       v = 32'hFFFF_FFFF;
            2:       v = $urandom_range(0, 32'h0010_0000);
            3:       v = $urandom_range(32'h0040_0000, 32'h0400_0000);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Sensor-like samples: a drifting level with noise, some jumps, some raw noise
    function automatic logic [15:0] next_measurement();
        int choice;
        int v;
        choice = $urandom_range(0, 99);
        if (choice < 75)
        begin
            level = level + int'($urandom_range(0, 400)) - 200;
            if (level > 32767)
                level = 32767;
            if (level < -32768)
                level = -32768;
            v = level + int'($urandom_range(0, 128)) - 64;
        end
        else if (choice < 85)
        begin
            level = int'($urandom_range(0, 65535)) - 32768;
            v = level;
        end
        else
            v = int'($urandom_range(0, 65535)) - 32768;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    // Main sequence: reset, directed cases, then randomised phases
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: extremes of the sample and alternating bits
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        drain_filter();

        // saturated covariance with unit gain: full-scale swings
        load_setting(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        drain_filter();

        // largest measurement noise on a saturated covariance
        write_reg(REG_MEASUREMENT_NOISE, 32'hFFFF_FFFF);
        send_sample(16'h8000);
        send_sample(16'd12345);
        drain_filter();

        // empty sum: gain stays zero, estimate must not move
        load_setting(32'd0, 32'd0, 32'd0);
        send_sample(16'd100);
        send_sample(-16'sd100);
        drain_filter();

        // a write to an unmapped index must change nothing
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_sample(16'd5000);
        drain_filter();

        // smallest non-zero values
        load_setting(32'd1, 32'd1, 32'd1);
        send_sample(16'h7FFF);
        send_sample(16'hFFFF);
        drain_filter();

        // randomised phases under three idling patterns
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    tx_idle_pct = 19;
                    rx_idle_pct = 51;
                end
                1:
                begin
                    tx_idle_pct = 51;
                    rx_idle_pct = 19;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int set = 0; set < SETS_PER_MODE; set++)
            begin
                write_reg(REG_PROCESS_NOISE, pick_cov_value());
                write_reg(REG_MEASUREMENT_NOISE, pick_cov_value());
                // sometimes carry the filter state over into the new setting
                if ($urandom_range(0, 2) != 0)
                    write_reg(REG_INITIAL_COVARIANCE, pick_cov_value());
                n_settings++;
                // long output stall while samples keep coming
                if (mode == 0 && set == 1)
                    holds_requested++;
                for (int k = 0; k < ITEMS_PER_SET; k++)
                    send_sample(next_measurement());
                drain_filter();
            end
        end

        $display("Summary: %0d filtered words checked over %0d register settings,",
                 n_checked, n_settings);
        $display("  incl. zero-sum gain, saturated covariance, unmapped write, long stall");
        if (n_errors == 0 && n_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### scalar_kalman_filter.f
sv/skf_pkg.sv
sv/skf_div.sv
sv/scalar_kalman_filter.sv
dv/skf_checker.sv
dv/tb.sv
